// File: src/lrgc_pkg.sv
// ----------------------------------------------------------------------------
// lrgc_pkg
// Shared widths, register indexes, reset values and types of the lidar ray
// ground classifier.
// ----------------------------------------------------------------------------
package lrgc_pkg;

  // payload widths
  localparam int RADIUS_W   = 18;
  localparam int HEIGHT_W   = 16;
  localparam int TAG_W_DEF  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_SLOPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GENERAL_SLOPE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONC_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECLASS_GAP   = 3'd5;

  // register reset values
  localparam logic [12:0] RST_SENSOR_HEIGHT = 13'd1730;
  localparam logic [15:0] RST_LOCAL_SLOPE   = 16'd9210;
  localparam logic [15:0] RST_GENERAL_SLOPE = 16'd5734;
  localparam logic [12:0] RST_MIN_HEIGHT    = 13'd50;
  localparam logic [12:0] RST_CONC_STEP     = 13'd10;
  localparam logic [15:0] RST_RECLASS_GAP   = 16'd200;

  // configuration register set
  typedef struct packed {
    logic [12:0] sensor_height;
    logic [15:0] local_slope_tan;
    logic [15:0] general_slope_tan;
    logic [12:0] min_height_thresh;
    logic [12:0] concentric_step;
    logic [15:0] reclass_gap;
  } cfg_t;

  // previous point of the ray, as held by the top level
  typedef struct packed {
    logic                       ray_open;
    logic [RADIUS_W-1:0]        radius;
    logic signed [HEIGHT_W-1:0] height;
    logic                       ground;
  } prev_t;

endpackage

// File: src/lrgc_in_if.sv
// ----------------------------------------------------------------------------
// lrgc_in_if
// Point channel: valid/ready handshake carrying one lidar point.
// ----------------------------------------------------------------------------
interface lrgc_in_if
  import lrgc_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_W_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       ray_start;
  logic [RADIUS_W-1:0]        radius_mm;
  logic signed [HEIGHT_W-1:0] height_mm;
  logic [TAG_WIDTH-1:0]       point_tag;

  modport source (output valid, ray_start, radius_mm, height_mm, point_tag,
                  input ready);
  modport sink   (input valid, ray_start, radius_mm, height_mm, point_tag,
                  output ready);
endinterface

// File: src/lrgc_out_if.sv
// ----------------------------------------------------------------------------
// lrgc_out_if
// Result channel: valid/ready handshake carrying one classification.
// ----------------------------------------------------------------------------
interface lrgc_out_if
  import lrgc_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_W_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 is_ground;
  logic [TAG_WIDTH-1:0] tag_out;

  modport source (output valid, is_ground, tag_out, input ready);
  modport sink   (input valid, is_ground, tag_out, output ready);
endinterface

// File: src/lrgc_cfg_if.sv
// ----------------------------------------------------------------------------
// lrgc_cfg_if
// Configuration write channel: valid/ready handshake with index and data.
// ----------------------------------------------------------------------------
interface lrgc_cfg_if
  import lrgc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/lrgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lrgc_cfg_regs
// Configuration register file; every write transaction is taken at once.
// ----------------------------------------------------------------------------
module lrgc_cfg_regs
  import lrgc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lrgc_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg           = cfg_r;

  // decode write; only the low bits of each register are kept
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SENSOR_HEIGHT: cfg_nxt.sensor_height     = cfg_ch.data[12:0];
        REG_LOCAL_SLOPE:   cfg_nxt.local_slope_tan   = cfg_ch.data[15:0];
        REG_GENERAL_SLOPE: cfg_nxt.general_slope_tan = cfg_ch.data[15:0];
        REG_MIN_HEIGHT:    cfg_nxt.min_height_thresh = cfg_ch.data[12:0];
        REG_CONC_STEP:     cfg_nxt.concentric_step   = cfg_ch.data[12:0];
        REG_RECLASS_GAP:   cfg_nxt.reclass_gap       = cfg_ch.data[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_height     <= RST_SENSOR_HEIGHT;
      cfg_r.local_slope_tan   <= RST_LOCAL_SLOPE;
      cfg_r.general_slope_tan <= RST_GENERAL_SLOPE;
      cfg_r.min_height_thresh <= RST_MIN_HEIGHT;
      cfg_r.concentric_step   <= RST_CONC_STEP;
      cfg_r.reclass_gap       <= RST_RECLASS_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/lrgc_classify.sv
// ----------------------------------------------------------------------------
// lrgc_classify
// Ground decision for one point against the previous point of its ray:
// local slope band, general slope band and large-gap reclassification.
// ----------------------------------------------------------------------------
module lrgc_classify
  import lrgc_pkg::*;
(
  input  cfg_t                       cfg,
  input  prev_t                      prev,
  input  logic                       ray_start,
  input  logic [RADIUS_W-1:0]        radius,
  input  logic signed [HEIGHT_W-1:0] height,
  output logic                       is_ground
);

  // common compare width: covers height +/- any band
  localparam int CW = 22;

  logic                       new_ray;
  logic [RADIUS_W-1:0]        prev_r;
  logic signed [HEIGHT_W-1:0] prev_h;
  logic                       prev_g;
  logic signed [HEIGHT_W-1:0] floor_h;

  logic signed [RADIUS_W:0]   step;
  logic signed [35:0]         loc_prod;
  logic [33:0]                gen_prod;
  logic signed [19:0]         band_raw;
  logic signed [19:0]         band;
  logic [17:0]                gband;
  logic                       use_min;

  logic signed [CW-1:0] h_x, ph_x, fh_x, b_x, gb_x;
  logic                 local_hit, general_hit, reclass_hit;

  // previous point, or the virtual start point below the sensor
  assign new_ray = ray_start || !prev.ray_open;
  assign floor_h = HEIGHT_W'(0) - {3'b000, cfg.sensor_height};
  assign prev_r  = new_ray ? '0      : prev.radius;
  assign prev_h  = new_ray ? floor_h : prev.height;
  assign prev_g  = new_ray ? 1'b0    : prev.ground;

  // signed radial step and slope products; upper bits give the floor of >>16
  assign step     = $signed({1'b0, radius}) - $signed({1'b0, prev_r});
  assign loc_prod = $signed({1'b0, cfg.local_slope_tan}) * step;
  assign gen_prod = cfg.general_slope_tan * radius;
  assign band_raw = loc_prod[35:16];
  assign gband    = gen_prod[33:16];

  // minimum band half width after a long step
  assign use_min = (step > $signed({6'b0, cfg.concentric_step})) &&
                   (band_raw < $signed({7'b0, cfg.min_height_thresh}));
  assign band    = use_min ? $signed({7'b0, cfg.min_height_thresh}) : band_raw;

  // extend everything to the compare width
  assign h_x  = {{(CW-HEIGHT_W){height[HEIGHT_W-1]}}, height};
  assign ph_x = {{(CW-HEIGHT_W){prev_h[HEIGHT_W-1]}}, prev_h};
  assign fh_x = {{(CW-HEIGHT_W){floor_h[HEIGHT_W-1]}}, floor_h};
  assign b_x  = {{(CW-20){band[19]}}, band};
  assign gb_x = {{(CW-18){1'b0}}, gband};

  // band checks
  assign local_hit   = (h_x <= ph_x + b_x) && (h_x >= ph_x - b_x);
  assign general_hit = (h_x <= fh_x + gb_x) && (h_x >= fh_x - gb_x);
  assign reclass_hit = (step > $signed({3'b0, cfg.reclass_gap})) &&
                       (h_x <= fh_x + b_x) && (h_x >= fh_x - b_x);

  always_comb begin
    if (local_hit) begin
      is_ground = prev_g || general_hit;
    end else begin
      is_ground = reclass_hit;
    end
  end

endmodule

// File: src/lidar_ray_ground_classifier.sv
// ----------------------------------------------------------------------------
// lidar_ray_ground_classifier
// Classifies lidar points of one angular ray, in order of rising radius, as
// ground or not ground, one result per point.
// ----------------------------------------------------------------------------
// Rate: one point per clock sustained while the sink takes results. A point is
// registered on acceptance, classified in the following cycle by the slope
// multipliers and band compares, and written to the output register together
// with the ray state, so the next point sees the updated state without a
// bubble. The result passes through the input register and then the output
// register before it is presented. The input keeps taking points while a
// result waits for the sink, until both registers are full.
// Configuration writes are taken in any cycle and must be made while idle.
// ----------------------------------------------------------------------------
module lidar_ray_ground_classifier
  import lrgc_pkg::*;
#(
  parameter int TAG_WIDTH = TAG_W_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  lrgc_in_if.sink     in_ch,
  lrgc_out_if.source  out_ch,
  lrgc_cfg_if.sink    cfg_ch
);

  cfg_t  cfg;
  prev_t prev;

  // input stage
  logic                       s_valid_r, s_valid_nxt;
  logic                       s_ray_start_r;
  logic [RADIUS_W-1:0]        s_radius_r;
  logic signed [HEIGHT_W-1:0] s_height_r;
  logic [TAG_WIDTH-1:0]       s_tag_r;

  // result stage
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ground_r;
  logic [TAG_WIDTH-1:0]       out_tag_r;

  // ray state
  logic                       ray_open_r;
  logic [RADIUS_W-1:0]        last_radius_r;
  logic signed [HEIGHT_W-1:0] last_height_r;
  logic                       last_ground_r;

  logic in_acc;
  logic s_adv;
  logic cls_ground;

  lrgc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign prev.ray_open = ray_open_r;
  assign prev.radius   = last_radius_r;
  assign prev.height   = last_height_r;
  assign prev.ground   = last_ground_r;

  lrgc_classify u_cls (
    .cfg       (cfg),
    .prev      (prev),
    .ray_start (s_ray_start_r),
    .radius    (s_radius_r),
    .height    (s_height_r),
    .is_ground (cls_ground)
  );

  // handshake control
  assign s_adv       = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s_valid_r || s_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_acc) begin
      s_valid_nxt = 1'b1;
    end else if (s_adv) begin
      s_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s_valid_r && s_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ray_open_r  <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s_valid_r && s_adv) begin
        ray_open_r <= 1'b1;
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_ray_start_r <= in_ch.ray_start;
      s_radius_r    <= in_ch.radius_mm;
      s_height_r    <= in_ch.height_mm;
      s_tag_r       <= in_ch.point_tag;
    end
  end

  // result payload and previous-point state
  always_ff @(posedge clk) begin
    if (s_valid_r && s_adv) begin
      out_ground_r  <= cls_ground;
      out_tag_r     <= s_tag_r;
      last_radius_r <= s_radius_r;
      last_height_r <= s_height_r;
      last_ground_r <= cls_ground;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_ground = out_ground_r;
  assign out_ch.tag_out   = out_tag_r;

  // a classified point always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_adv) |=> out_valid_r)
    else $error("classified point not presented");

  // the result tag is the tag of the point that moved forward
  a_tag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_adv) |=> (out_tag_r == $past(s_tag_r)))
    else $error("result tag does not match point");

  // input is only held off when both stages are full and the sink stalls
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without cause");

  // once a point has been classified the ray stays open
  a_ray_open: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_adv) |=> ray_open_r)
    else $error("ray state not opened");

endmodule
